/* sv/bbsf_pkg.sv */
// Package for the bounded byte stream FIFO: opcodes, word types and state encoding.
package bbsf_pkg;

  // Width of the count fields (capacity, pop count, buffered and free counts).
  localparam int CNT_W = 13;

  // Capacity after reset.
  localparam logic [CNT_W-1:0] CAP_RESET = 13'd4096;

  // Register index of the capacity register.
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;
  localparam logic [1:0] OP_ERROR = 2'd3;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [7:0]       data_byte;
    logic [CNT_W-1:0] pop_count;
  } bbsf_in_t;

  typedef struct packed {
    logic             accepted;
    logic [CNT_W-1:0] removed_count;
    logic [7:0]       front_byte;
    logic             front_valid;
    logic [CNT_W-1:0] buffered_count;
    logic [CNT_W-1:0] free_count;
    logic [63:0]      pushed_total;
    logic [63:0]      popped_total;
    logic             closed_flag;
    logic             error_flag;
    logic             finished;
  } bbsf_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } bbsf_state_t;

endpackage

/* sv/bounded_byte_stream_fifo_core.sv */
// Bounded byte stream FIFO core: byte store, pointer and counter update, APB capacity register.
// An accepted word takes the FSM to ST_LOOK, which loads its result into the output register
// once that register is free and only then returns to ST_IDLE to take the next word. The front
// byte of each result is the registered read of the byte store at the updated read pointer.
// Reset (rst_n low, synchronous) clears pointers, held count, totals, flags and the output
// valid and sets capacity to 4096; the byte store itself is not cleared.
module bounded_byte_stream_fifo_core #(
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Input word channel.
  input  logic                     in_valid,
  output logic                     in_ready,
  input  bbsf_pkg::bbsf_in_t       in_data,
  // Result word channel.
  output logic                     out_valid,
  input  logic                     out_ready,
  output bbsf_pkg::bbsf_out_t      out_data,
  // APB-style configuration port.
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int CW = bbsf_pkg::CNT_W;
  // Pointer width; one bit is the minimum so that DEPTH of two still indexes.
  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  // Width for pointer sums and comparisons against DEPTH.
  localparam int SW = ((AW > CW) ? AW : CW) + 1;
  localparam logic [SW-1:0] DEPTH_W = SW'(DEPTH);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  // The byte store. Reads may hit unwritten entries; the front byte is shown only when bytes are held.
  logic [7:0] mem [DEPTH];

  bbsf_pkg::bbsf_state_t state_r, state_nxt;

  logic [CW-1:0] cap_r, cap_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [63:0]   pushed_r, pushed_nxt;
  logic [63:0]   popped_r, popped_nxt;
  logic          closed_r, closed_nxt;
  logic          error_r, error_nxt;

  // Per-word results carried from the accept cycle to the lookup cycle.
  logic          acc_r, acc_nxt;
  logic [CW-1:0] removed_r, removed_nxt;
  // A push into an empty FIFO lands at the very address being read, so the
  // pushed byte is forwarded around the store instead of the stale read data.
  logic          fwd_r, fwd_nxt;
  logic [7:0]    fwd_byte_r, fwd_byte_nxt;
  logic [7:0]    rd_data_r;

  bbsf_pkg::bbsf_out_t out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic          accept;
  logic          out_load;
  logic          cfg_write;
  logic [SW-1:0] cap_eff;
  logic [SW-1:0] held_ext;
  logic [SW-1:0] free_w;
  logic          can_push;
  logic          push_ok;
  logic          is_pop;
  logic [CW-1:0] removed_w;
  logic [SW-1:0] rsum;
  logic [SW-1:0] rwrap;
  logic [AW-1:0] rptr_pop;
  logic [AW-1:0] wptr_inc;
  logic [7:0]    front_w;

  assign accept    = in_valid && in_ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // Register reads: only the capacity register exists, everything else reads zero.
  always_comb begin
    prdata = '0;
    if (paddr[2] == bbsf_pkg::REG_CAPACITY) begin
      prdata = {{(32 - CW){1'b0}}, cap_r};
    end
  end

  // Effective capacity saturates at the store depth. Lowering capacity below
  // the held count discards nothing; free space then reads zero.
  always_comb begin
    cap_eff  = (SW'(cap_r) > DEPTH_W) ? DEPTH_W : SW'(cap_r);
    held_ext = SW'(held_r);
    free_w   = (cap_eff > held_ext) ? (cap_eff - held_ext) : '0;
    can_push = (free_w != '0) && (held_ext < DEPTH_W);
  end

  // Pointer arithmetic. A pop never removes more than DEPTH bytes, so one
  // conditional subtract brings the read pointer back into range.
  always_comb begin
    removed_w = (in_data.pop_count < held_r) ? in_data.pop_count : held_r;
    rsum      = SW'(rptr_r) + SW'(removed_w);
    rwrap     = (rsum >= DEPTH_W) ? (rsum - DEPTH_W) : rsum;
    rptr_pop  = rwrap[AW-1:0];
    wptr_inc  = (wptr_r == LAST_PTR) ? '0 : (wptr_r + AW'(1));
  end

  assign push_ok = accept && (in_data.opcode == bbsf_pkg::OP_PUSH) && can_push;
  assign is_pop  = accept && (in_data.opcode == bbsf_pkg::OP_POP);

  // State update for an accepted word. Flags are sticky and do not block pushes.
  always_comb begin
    cap_nxt      = cap_r;
    rptr_nxt     = rptr_r;
    wptr_nxt     = wptr_r;
    held_nxt     = held_r;
    pushed_nxt   = pushed_r;
    popped_nxt   = popped_r;
    closed_nxt   = closed_r;
    error_nxt    = error_r;
    acc_nxt      = acc_r;
    removed_nxt  = removed_r;
    fwd_nxt      = fwd_r;
    fwd_byte_nxt = fwd_byte_r;

    if (cfg_write && (paddr[2] == bbsf_pkg::REG_CAPACITY)) begin
      cap_nxt = pwdata[CW-1:0];
    end

    if (accept) begin
      acc_nxt      = 1'b0;
      removed_nxt  = '0;
      fwd_nxt      = 1'b0;
      fwd_byte_nxt = in_data.data_byte;
      case (in_data.opcode)
        bbsf_pkg::OP_PUSH: begin
          if (can_push) begin
            wptr_nxt   = wptr_inc;
            held_nxt   = held_r + CW'(1);
            pushed_nxt = pushed_r + 64'd1;
            acc_nxt    = 1'b1;
            fwd_nxt    = (held_r == '0);
          end
        end
        bbsf_pkg::OP_POP: begin
          removed_nxt = removed_w;
          rptr_nxt    = rptr_pop;
          held_nxt    = held_r - removed_w;
          popped_nxt  = popped_r + {{(64 - CW){1'b0}}, removed_w};
        end
        bbsf_pkg::OP_CLOSE: begin
          closed_nxt = 1'b1;
        end
        default: begin
          error_nxt = 1'b1;
        end
      endcase
    end
  end

  // Byte store: write the pushed byte and read the front at the new read pointer.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wptr_r] <= in_data.data_byte;
    end
    if (accept) begin
      rd_data_r <= mem[is_pop ? rptr_pop : rptr_r];
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bbsf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = bbsf_pkg::ST_LOOK;
        end
      end
      bbsf_pkg::ST_LOOK: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = bbsf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bbsf_pkg::ST_IDLE;
    endcase
  end

  // FSM outputs. The output register lets the next word in while a result waits.
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      bbsf_pkg::ST_IDLE: in_ready = 1'b1;
      bbsf_pkg::ST_LOOK: out_load = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // Result assembly during the lookup cycle from the updated state.
  always_comb begin
    front_w = '0;
    if (held_r != '0) begin
      front_w = fwd_r ? fwd_byte_r : rd_data_r;
    end
    out_nxt                = out_r;
    out_valid_nxt          = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt          = 1'b1;
      out_nxt.accepted       = acc_r;
      out_nxt.removed_count  = removed_r;
      out_nxt.front_byte     = front_w;
      out_nxt.front_valid    = (held_r != '0);
      out_nxt.buffered_count = held_r;
      out_nxt.free_count     = free_w[CW-1:0];
      out_nxt.pushed_total   = pushed_r;
      out_nxt.popped_total   = popped_r;
      out_nxt.closed_flag    = closed_r;
      out_nxt.error_flag     = error_r;
      out_nxt.finished       = closed_r && (held_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bbsf_pkg::ST_IDLE;
      cap_r       <= bbsf_pkg::CAP_RESET;
      rptr_r      <= '0;
      wptr_r      <= '0;
      held_r      <= '0;
      pushed_r    <= '0;
      popped_r    <= '0;
      closed_r    <= 1'b0;
      error_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      rptr_r      <= rptr_nxt;
      wptr_r      <= wptr_nxt;
      held_r      <= held_nxt;
      pushed_r    <= pushed_nxt;
      popped_r    <= popped_nxt;
      closed_r    <= closed_nxt;
      error_r     <= error_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    removed_r  <= removed_nxt;
    fwd_r      <= fwd_nxt;
    fwd_byte_r <= fwd_byte_nxt;
    out_r      <= out_nxt;
  end

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    SW'(held_r) <= DEPTH_W)
    else $error("held count exceeds store depth");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (SW'(rptr_r) < DEPTH_W) && (SW'(wptr_r) < DEPTH_W))
    else $error("pointer outside store");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r == '0) |-> (rptr_r == wptr_r))
    else $error("empty FIFO with differing pointers");

  a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == bbsf_pkg::ST_LOOK) && !in_ready)
    else $error("accepted word did not enter lookup");

  a_push_xor_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.accepted && (out_r.removed_count != '0)))
    else $error("result both stored and removed bytes");
`endif

endmodule
